[src/scr_pkg.sv]
// Shared types and constants for the SCPI command recognizer.
// Holds result and error codes, the fixed command text table and the match control struct.
// No dependencies.
`timescale 1ns / 1ps

package scr_pkg;

    // Input item kinds
    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Result codes
    localparam logic [2:0] CODE_OVERRUN   = 3'd0;
    localparam logic [2:0] CODE_UNDEFINED = 3'd1;
    localparam logic [2:0] CODE_FIRST_CMD = 3'd2;

    // Error queue entries
    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_UNDEF_HEADER = 2'd1;
    localparam logic [1:0] ERR_OVERRUN      = 2'd2;

    // Command table
    localparam int NUM_CMDS    = 5;
    localparam int CMD_MAX_LEN = 10;
    localparam int CMD_IDX_W   = 4;

    localparam int CMD_IDN      = 0;
    localparam int CMD_RST      = 1;
    localparam int CMD_MEAS     = 2;
    localparam int CMD_SYST_UPT = 3;
    localparam int CMD_SYST_ERR = 4;

    localparam logic [CMD_IDX_W-1:0] CMD_LEN [NUM_CMDS] = '{
        4'd5, 4'd4, 4'd10, 4'd9, 4'd9
    };

    // Upper-case command text, zero padded
    localparam logic [7:0] CMD_TEXT [NUM_CMDS][CMD_MAX_LEN] = '{
        // *IDN?
        '{8'h2A, 8'h49, 8'h44, 8'h4E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        // *RST
        '{8'h2A, 8'h52, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        // MEAS:TEMP?
        '{8'h4D, 8'h45, 8'h41, 8'h53, 8'h3A, 8'h54, 8'h45, 8'h4D, 8'h50, 8'h3F},
        // SYST:UPT?
        '{8'h53, 8'h59, 8'h53, 8'h54, 8'h3A, 8'h55, 8'h50, 8'h54, 8'h3F, 8'h00},
        // SYST:ERR?
        '{8'h53, 8'h59, 8'h53, 8'h54, 8'h3A, 8'h45, 8'h52, 8'h52, 8'h3F, 8'h00}
    };

    // Control from the sequencer to the match unit
    typedef struct packed {
        logic                 load;
        logic                 step;
        logic [CMD_IDX_W-1:0] len;
        logic [CMD_IDX_W-1:0] idx;
    } scr_match_ctl_t;

endpackage

[src/scr_store.sv]
// Command byte store: one write port, one read port with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module scr_store #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
    input  logic [7:0]                      wr_data,
    input  logic                            rd_en,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
    output logic [7:0]                      rd_data
);

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/scr_match.sv]
// Match unit: keeps one candidate bit per command, narrowed one stored byte at a time.
// Depends on scr_pkg.
`timescale 1ns / 1ps

module scr_match (
    input  logic                       clk,
    input  logic                       rst_n,
    input  scr_pkg::scr_match_ctl_t    ctl,
    input  logic [7:0]                 rd_data,
    output logic [scr_pkg::NUM_CMDS-1:0] mask
);

    logic [scr_pkg::NUM_CMDS-1:0] mask_reg;
    logic [scr_pkg::NUM_CMDS-1:0] mask_next;
    logic [7:0]                   folded;

    // Fold a-z to upper case before comparing
    assign folded = (rd_data >= 8'h61 && rd_data <= 8'h7A) ? rd_data - 8'h20 : rd_data;

    always_comb
    begin
        mask_next = mask_reg;
        if (ctl.load)
        begin
            for (int k = 0; k < scr_pkg::NUM_CMDS; k++)
            begin
                mask_next[k] = (ctl.len == scr_pkg::CMD_LEN[k]);
            end
        end
        else if (ctl.step)
        begin
            for (int k = 0; k < scr_pkg::NUM_CMDS; k++)
            begin
                if (scr_pkg::CMD_TEXT[k][ctl.idx] != folded)
                begin
                    mask_next[k] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    assign mask = mask_reg;

endmodule

[src/scpi_command_recognizer.sv]
// Top level of the SCPI command recognizer: sequencer, length tracking and error queue.
// Depends on scr_pkg, scr_store and scr_match.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): one transfer per message byte or device
//   clear. Message bytes without end_of_message leave the block idle, so a message
//   streams in at one byte per cycle with in_stall low.
//   A byte with end_of_message starts recognition: the block reads back up to ten
//   stored bytes from the store memory (one read per cycle, registered read
//   data), then resolves the command. in_stall stays high through the read
//   sweep and the resolve step (a discarded message skips the sweep; a
//   blank-only or out-of-range message reads no bytes), and for as long as the
//   output register stays full.
//   Output channel (out_valid / out_stall): one result transfer per ended
//   message, held in an output register. A new message is accepted while a
//   result waits; the next result waits in the resolve step until the output
//   register frees up, holding in_stall high meanwhile.
//   Reset clears the length, the discard flag and the error queue; the store
//   memory is not cleared, since only written entries are ever read.
module scpi_command_recognizer #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       mode,
    input  logic [7:0] data_byte,
    input  logic       start_of_message,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] command_code,
    output logic [1:0] reported_error,
    output logic       error_pending
);

    localparam int LW = $clog2(BUFFER_DEPTH);
    localparam logic [LW-1:0] MAX_LEN = LW'(BUFFER_DEPTH - 1);
    localparam logic [LW-1:0] SCAN_LIMIT = LW'(scr_pkg::CMD_MAX_LEN);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } scr_state_t;

    scr_state_t state_reg, state_next;

    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] nonws_reg, nonws_next;   // length with trailing blanks stripped
    logic          discard_reg, discard_next;
    logic [1:0]    err_reg, err_next;
    logic          overrun_reg, overrun_next;

    logic [scr_pkg::CMD_IDX_W-1:0] scan_len_reg, scan_len_next;
    logic [scr_pkg::CMD_IDX_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [scr_pkg::CMD_IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic                          cmp_valid_reg, cmp_valid_next;

    logic       out_valid_reg, out_valid_next;
    logic [2:0] code_reg, code_next;
    logic [1:0] rep_reg, rep_next;
    logic       pend_reg, pend_next;

    logic          accept;
    logic          out_free;
    logic [LW-1:0] base_len;
    logic [LW-1:0] base_nonws;
    logic          base_discard;
    logic          full;
    logic          is_blank;
    logic [LW-1:0] grown_len;
    logic [LW-1:0] grown_nonws;

    logic          mem_wr_en;
    logic          mem_rd_en;
    logic [LW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    scr_pkg::scr_match_ctl_t       match_ctl;
    logic [scr_pkg::NUM_CMDS-1:0]  mask;
    logic [2:0]                    hit_code;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Start of message restarts length and discard before this byte is stored
    assign base_len     = start_of_message ? '0 : len_reg;
    assign base_nonws   = start_of_message ? '0 : nonws_reg;
    assign base_discard = start_of_message ? 1'b0 : discard_reg;
    assign full         = (base_len >= MAX_LEN);
    assign is_blank     = (data_byte == 8'h0A) || (data_byte == 8'h0D) || (data_byte == 8'h20);
    assign grown_len    = full ? base_len : base_len + LW'(1);
    assign grown_nonws  = (full || is_blank) ? base_nonws : base_len + LW'(1);

    assign mem_wr_en   = accept && (mode == scr_pkg::MODE_BYTE) && !full;
    assign mem_rd_addr = LW'(scan_cnt_reg);

    scr_store #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (base_len),
        .wr_data (data_byte),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    scr_match u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (match_ctl),
        .rd_data (mem_rd_data),
        .mask    (mask)
    );

    // Candidate bits are mutually exclusive; pick the code of the one left
    always_comb
    begin
        hit_code = scr_pkg::CODE_UNDEFINED;
        for (int k = scr_pkg::NUM_CMDS - 1; k >= 0; k--)
        begin
            if (mask[k])
            begin
                hit_code = scr_pkg::CODE_FIRST_CMD + 3'(k);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        nonws_next     = nonws_reg;
        discard_next   = discard_reg;
        err_next       = err_reg;
        overrun_next   = overrun_reg;
        scan_len_next  = scan_len_reg;
        scan_cnt_next  = scan_cnt_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = 1'b0;
        code_next      = code_reg;
        rep_next       = rep_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_rd_en      = 1'b0;
        match_ctl      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == scr_pkg::MODE_CLEAR)
                    begin
                        len_next     = '0;
                        nonws_next   = '0;
                        discard_next = 1'b0;
                    end
                    else
                    begin
                        len_next     = grown_len;
                        nonws_next   = grown_nonws;
                        discard_next = base_discard || full;
                        if (end_of_message)
                        begin
                            overrun_next = base_discard || full;
                            if (base_discard || full)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                // Strip trailing blanks; anything longer than the
                                // longest command scans as length zero and misses
                                len_next      = grown_nonws;
                                scan_len_next = (grown_nonws > SCAN_LIMIT) ? '0
                                                : grown_nonws[scr_pkg::CMD_IDX_W-1:0];
                                scan_cnt_next = '0;
                                match_ctl.load = 1'b1;
                                match_ctl.len  = (grown_nonws > SCAN_LIMIT) ? '0
                                                 : grown_nonws[scr_pkg::CMD_IDX_W-1:0];
                                state_next     = ST_SCAN;
                            end
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle; compare each byte in the cycle after its read
                if (scan_cnt_reg < scan_len_reg)
                begin
                    mem_rd_en      = 1'b1;
                    scan_cnt_next  = scan_cnt_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_cnt_reg;
                end
                match_ctl.step = cmp_valid_reg;
                match_ctl.idx  = cmp_idx_reg;
                if ((scan_len_reg == '0) ||
                    (cmp_valid_reg && (cmp_idx_reg == scan_len_reg - 1'b1)))
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold the result here until the output register is free
                if (out_free)
                begin
                    rep_next = scr_pkg::ERR_NONE;
                    if (overrun_reg)
                    begin
                        code_next = scr_pkg::CODE_OVERRUN;
                        if (err_reg == scr_pkg::ERR_NONE)
                        begin
                            err_next = scr_pkg::ERR_OVERRUN;
                        end
                    end
                    else if (mask == '0)
                    begin
                        code_next = scr_pkg::CODE_UNDEFINED;
                        if (err_reg == scr_pkg::ERR_NONE)
                        begin
                            err_next = scr_pkg::ERR_UNDEF_HEADER;
                        end
                    end
                    else
                    begin
                        code_next = hit_code;
                        if (mask[scr_pkg::CMD_RST])
                        begin
                            err_next = scr_pkg::ERR_NONE;
                        end
                        if (mask[scr_pkg::CMD_SYST_ERR])
                        begin
                            rep_next = err_reg;
                            err_next = scr_pkg::ERR_NONE;
                        end
                    end
                    pend_next      = (err_next != scr_pkg::ERR_NONE);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            nonws_reg     <= '0;
            discard_reg   <= 1'b0;
            err_reg       <= scr_pkg::ERR_NONE;
            overrun_reg   <= 1'b0;
            scan_len_reg  <= '0;
            scan_cnt_reg  <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            nonws_reg     <= nonws_next;
            discard_reg   <= discard_next;
            err_reg       <= err_next;
            overrun_reg   <= overrun_next;
            scan_len_reg  <= scan_len_next;
            scan_cnt_reg  <= scan_cnt_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        rep_reg  <= rep_next;
        pend_reg <= pend_next;
    end

    assign out_valid      = out_valid_reg;
    assign command_code   = code_reg;
    assign reported_error = rep_reg;
    assign error_pending  = pend_reg;

    // The stripped length never runs past the stored length
    a_nonws_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nonws_reg <= len_reg)
        else $error("stripped length exceeds stored length");

    // The store never holds more than its depth minus one
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= MAX_LEN)
        else $error("stored length beyond store depth");

    // Store writes and read-back sweeps never overlap
    a_rw_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |-> !mem_wr_en)
        else $error("store read and write in the same cycle");

    // A compare only lands while the sweep runs
    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (state_reg == ST_SCAN))
        else $error("byte compare outside scan");

    // A new result only comes out of the resolve step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside resolve step");

    // At most one command survives the compare
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && !overrun_reg) |-> $onehot0(mask))
        else $error("more than one command matched");

endmodule
